FILE: rtl/mtpc_pkg.sv
package mtpc_pkg;

    // Field widths of the item payloads.
    localparam int MV_W    = 12;
    localparam int PCT_W   = 7;
    localparam int PHASE_W = 2;

    // Quotient bits the divider resolves; anything at or above 2**QUO_W saturates.
    localparam int QUO_W   = 7;
    // Width of (mv - wet) * 100 for millivolts below 2500.
    localparam int NUM_W   = 18;

    // Arithmetic constants.
    localparam int FULL_SCALE_MV = 2500;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
    localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;

    // Calibration reference values after reset.
    localparam logic [MV_W-1:0] DRY_RESET_MV  = 12'd2200;
    localparam logic [MV_W-1:0] WET_RESET_MV  = 12'd1100;
    localparam logic [MV_W-1:0] SPAN_RESET_MV = 12'd1100;
    localparam logic [MV_W-1:0] SPAN_MIN      = 12'd1;

    // Calibration phase codes.
    localparam logic [PHASE_W-1:0] PH_DRY = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WET = 2'd1;
    localparam logic [PHASE_W-1:0] PH_OK  = 2'd2;

    // Operation codes.
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_CAL     = 1'b1;

    typedef struct packed {
        logic            op;
        logic [11:0]     adc_sample;
    } t_in;

    typedef struct packed {
        logic [MV_W-1:0]    millivolts;
        logic [PCT_W-1:0]   moisture_percent;
        logic               is_calibrated;
        logic [PHASE_W-1:0] cal_phase;
    } t_out;

endpackage

FILE: rtl/mtpc_div.sv
// Restoring divider for the moisture level: one compare and subtract per cycle.
// It resolves QUO_W quotient bits after a first step that detects saturation,
// and returns 100 minus the level clamped at 100.
module mtpc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mtpc_pkg::NUM_W-1:0]  i_num,
    input  logic [mtpc_pkg::MV_W-1:0]   i_den,
    output logic                        o_done,
    output logic [mtpc_pkg::PCT_W-1:0]  o_pct
);

    localparam int NumW = mtpc_pkg::NUM_W;
    localparam int QuoW = mtpc_pkg::QUO_W;
    localparam int DshW = mtpc_pkg::MV_W + QuoW;
    localparam int CntW = $clog2(QuoW + 1);
    localparam int PctW = mtpc_pkg::PCT_W;
    localparam logic [CntW-1:0] CntTop = CntW'(QuoW);

    logic                r_busy;
    logic                r_done;
    logic [CntW-1:0]     r_k;
    logic [NumW-1:0]     r_rem;
    logic [DshW-1:0]     r_dsh;
    logic [QuoW-1:0]     r_q;
    logic [PctW-1:0]     r_pct;

    logic                w_ge;
    logic [QuoW-1:0]     w_q_final;

    // Shared compare of the remainder against the shifted divisor.
    assign w_ge      = DshW'(r_rem) >= r_dsh;
    assign w_q_final = {r_q[QuoW-2:0], w_ge};

    // Sequencer and datapath registers of the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_k    <= CntTop;
                r_rem  <= i_num;
                r_dsh  <= {i_den, QuoW'(0)};
                r_q    <= '0;
            end else if (r_busy) begin
                r_dsh <= r_dsh >> 1;
                r_q   <= w_q_final;
                r_k   <= r_k - 1'b1;
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh[NumW-1:0];
                end
                if (r_k == CntTop && w_ge) begin
                    // Level of 128 or more: fully dry.
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_pct  <= mtpc_pkg::PCT_ZERO;
                end else if (r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (w_q_final > mtpc_pkg::PCT_MAX) begin
                        r_pct <= mtpc_pkg::PCT_ZERO;
                    end else begin
                        r_pct <= mtpc_pkg::PCT_MAX - w_q_final;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_pct  = r_pct;

endmodule

FILE: rtl/moisture_two_point_calibration.sv
// An accepted item passes S_PREP, S_DIV while the divider runs, and S_OUT, where it waits to
// load the result register; a fixed result (uncalibrated or wet) skips S_DIV, and the divider
// stops early on a level of 128 or more. The 8-step divider and output stalls pace the items.
// The input is not ready while an item is in progress or its result cannot be loaded.
// Reset (synchronous, active low) returns to the dry phase, uncalibrated, with
// references of 2200 mV dry, 1100 mV wet and a span of 1100 mV.
module moisture_two_point_calibration #(
    parameter int ADC_BITS = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  mtpc_pkg::t_in   i_in_data,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output mtpc_pkg::t_out  o_out_data,
    input  logic            i_out_ready
);

    localparam int MvW   = mtpc_pkg::MV_W;
    localparam int NumW  = mtpc_pkg::NUM_W;
    localparam int PctW  = mtpc_pkg::PCT_W;
    localparam int PhW   = mtpc_pkg::PHASE_W;
    localparam int ProdW = ADC_BITS + MvW;
    localparam logic [ProdW-1:0] SampMask = ProdW'((64'd1 << ADC_BITS) - 64'd1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [PhW-1:0]      r_phase;
    logic [MvW-1:0]      r_dry;
    logic [MvW-1:0]      r_wet;
    logic [MvW-1:0]      r_span;
    logic                r_cal;
    logic [MvW-1:0]      r_mv;
    logic [PctW-1:0]     r_pct;
    logic                r_out_valid;
    mtpc_pkg::t_out      r_out;

    logic [PhW-1:0]      n_phase;
    logic [MvW-1:0]      n_dry;
    logic [MvW-1:0]      n_wet;
    logic [MvW-1:0]      n_span;
    logic                n_cal;

    logic                w_accept;
    logic [ProdW-1:0]    w_prod;
    logic [ProdW-1:0]    w_shift;
    logic [MvW-1:0]      w_mv;
    logic [MvW-1:0]      w_diff;
    logic [NumW-1:0]     w_num;
    logic [MvW-1:0]      w_den;
    logic                w_start;
    logic                w_div_done;
    logic [PctW-1:0]     w_div_pct;
    logic                w_load;

    assign w_accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Sample to millivolts: bits above the converter width are dropped.
    assign w_prod  = (ProdW'(i_in_data.adc_sample) & SampMask) * ProdW'(mtpc_pkg::FULL_SCALE_MV);
    assign w_shift = w_prod >> ADC_BITS;
    assign w_mv    = w_shift[MvW-1:0];

    // Calibration step applied on acceptance of a calibration item.
    always_comb begin
        n_phase = r_phase;
        n_dry   = r_dry;
        n_wet   = r_wet;
        n_span  = r_span;
        n_cal   = r_cal;
        if (w_accept && i_in_data.op == mtpc_pkg::OP_CAL) begin
            case (r_phase)
                mtpc_pkg::PH_DRY: begin
                    n_cal   = 1'b0;
                    n_dry   = w_mv;
                    n_phase = mtpc_pkg::PH_WET;
                end
                mtpc_pkg::PH_WET: begin
                    n_wet   = w_mv;
                    n_span  = (r_dry > w_mv) ? (r_dry - w_mv) : mtpc_pkg::SPAN_MIN;
                    n_cal   = 1'b1;
                    n_phase = mtpc_pkg::PH_OK;
                end
                default: begin
                    n_phase = mtpc_pkg::PH_DRY;
                end
            endcase
        end
    end

    // Numerator and divisor for the level computation.
    assign w_diff  = r_mv - r_wet;
    assign w_num   = NumW'(w_diff) * NumW'(mtpc_pkg::PCT_MAX);
    assign w_den   = (r_span == '0) ? mtpc_pkg::SPAN_MIN : r_span;
    assign w_start = (r_state == S_PREP) && r_cal && (r_mv > r_wet);

    mtpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_pct   (w_div_pct)
    );

    // The result register is loaded once it is empty or being taken.
    assign w_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Sequencer, calibration state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= mtpc_pkg::PH_DRY;
            r_dry       <= mtpc_pkg::DRY_RESET_MV;
            r_wet       <= mtpc_pkg::WET_RESET_MV;
            r_span      <= mtpc_pkg::SPAN_RESET_MV;
            r_cal       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_dry   <= n_dry;
            r_wet   <= n_wet;
            r_span  <= n_span;
            r_cal   <= n_cal;

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mv    <= w_mv;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (!r_cal) begin
                        r_pct   <= mtpc_pkg::PCT_ZERO;
                        r_state <= S_OUT;
                    end else if (r_mv <= r_wet) begin
                        r_pct   <= mtpc_pkg::PCT_MAX;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_pct   <= w_div_pct;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_out_valid            <= 1'b1;
                        r_out.millivolts       <= r_mv;
                        r_out.moisture_percent <= r_pct;
                        r_out.is_calibrated    <= r_cal;
                        r_out.cal_phase        <= r_phase;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A calibrated block is never waiting for its wet reference.
    a_cal_not_wet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal |-> (r_phase != mtpc_pkg::PH_WET))
        else $error("calibrated flag set in the wet phase");

    // The span is never zero, so the divider always sees a real divisor.
    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_span != '0)
        else $error("calibration span is zero");

    // An uncalibrated result reads zero percent.
    a_uncal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.is_calibrated) |-> (r_out.moisture_percent == mtpc_pkg::PCT_ZERO))
        else $error("uncalibrated item with nonzero moisture");

    // Moisture never exceeds full scale.
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.moisture_percent <= mtpc_pkg::PCT_MAX))
        else $error("moisture above 100 percent");

    // The divider only reports back while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

endmodule

FILE: dv/tb_moisture_two_point_calibration.sv
module tb_moisture_two_point_calibration;
    import mtpc_pkg::*;

    localparam int SAMPLE_BITS    = 12;
    localparam int PCT_FULL       = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int REPORT_LIMIT   = 10;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_item   = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    t_out out_item;

    // Calibration state as the block should hold it.
    logic [PHASE_W-1:0] phase_s      = PH_DRY;
    logic [MV_W-1:0]    dry_mv_s     = DRY_RESET_MV;
    logic [MV_W-1:0]    wet_mv_s     = WET_RESET_MV;
    logic [MV_W-1:0]    span_mv_s    = SPAN_RESET_MV;
    logic               calibrated_s = 1'b0;

    // Readings predicted for accepted items, oldest first.
    t_out pending_readings[$];

    bit idle_on         = 1'b1;
    int stall_left      = 0;
    int quiet_cycles    = 0;
    int items_sent      = 0;
    int cal_steps       = 0;
    int measurements    = 0;
    int partial_reads   = 0;
    int results_checked = 0;
    int fail_count      = 0;

    moisture_two_point_calibration dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_item),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_out_data  (out_item),
        .i_out_ready (out_ready)
    );

    always #1 clk = ~clk;

    // Works out the reading for one item and advances the calibration state.
    function automatic t_out predict_reading(input t_in item);
        t_out        r;
        int unsigned mv;
        int unsigned level;
        mv = (32'(item.adc_sample) * 32'(FULL_SCALE_MV)) >> SAMPLE_BITS;
        if (item.op == OP_CAL) begin
            cal_steps++;
            case (phase_s)
                PH_DRY: begin
                    calibrated_s = 1'b0;
                    dry_mv_s     = mv[MV_W-1:0];
                    phase_s      = PH_WET;
                end
                PH_WET: begin
                    wet_mv_s     = mv[MV_W-1:0];
                    span_mv_s    = (dry_mv_s > wet_mv_s) ? dry_mv_s - wet_mv_s : SPAN_MIN;
                    calibrated_s = 1'b1;
                    phase_s      = PH_OK;
                end
                default: begin
                    phase_s = PH_DRY;
                end
            endcase
        end else begin
            measurements++;
        end
        r.millivolts = mv[MV_W-1:0];
        if (!calibrated_s) begin
            r.moisture_percent = PCT_ZERO;
        end else if (mv <= wet_mv_s) begin
            r.moisture_percent = PCT_MAX;
        end else begin
            level = ((mv - wet_mv_s) * PCT_FULL) / span_mv_s;
            if (level > PCT_FULL) begin
                level = PCT_FULL;
            end
            r.moisture_percent = PCT_W'(PCT_FULL - level);
        end
        if (r.moisture_percent != PCT_ZERO && r.moisture_percent != PCT_MAX) begin
            partial_reads++;
        end
        r.is_calibrated = calibrated_s;
        r.cal_phase     = phase_s;
        return r;
    endfunction

    // Offers one item, possibly after an idle burst, and records its reading once taken.
    // Valid is left high on return; the next item or a drain decides what follows.
    task automatic send_item(input logic op, input logic [11:0] sample);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{op: op, adc_sample: sample};
        do @(posedge clk); while (!in_ready);
        pending_readings.push_back(predict_reading(in_item));
        items_sent++;
    endtask

    // Stops offering items and waits for every outstanding reading.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_readings.size() != 0);
    endtask

    // Steps the calibration sequence round until the dry phase is reached.
    task automatic advance_to_dry();
        while (phase_s != PH_DRY) begin
            send_item(OP_CAL, 12'($urandom_range(0, 4095)));
        end
    endtask

    // Readings before any calibration, including the sample extremes.
    task automatic test_uncalibrated_readings();
        send_item(OP_MEASURE, 12'd0);
        send_item(OP_MEASURE, 12'hFFF);
        send_item(OP_MEASURE, 12'hAAA);
        send_item(OP_MEASURE, 12'h555);
    endtask

    // A full dry, wet and ok cycle, then readings across and beyond the references.
    task automatic test_calibration_cycle();
        advance_to_dry();
        send_item(OP_CAL, 12'd3604);
        send_item(OP_CAL, 12'd1802);
        send_item(OP_MEASURE, 12'd1802);
        send_item(OP_MEASURE, 12'd1804);
        send_item(OP_MEASURE, 12'd2703);
        send_item(OP_MEASURE, 12'd3604);
        send_item(OP_MEASURE, 12'hFFF);
        send_item(OP_MEASURE, 12'd0);
        // Back to dry keeps the references and the calibrated flag.
        send_item(OP_CAL, 12'd100);
        send_item(OP_MEASURE, 12'd2703);
        // A fresh dry capture drops the calibrated flag.
        send_item(OP_CAL, 12'd3000);
        send_item(OP_MEASURE, 12'd2703);
    endtask

    // Wet captured above and then equal to dry, which forces the minimum span.
    task automatic test_inverted_references();
        advance_to_dry();
        send_item(OP_CAL, 12'd1000);
        send_item(OP_CAL, 12'd3000);
        send_item(OP_MEASURE, 12'd3000);
        send_item(OP_MEASURE, 12'd3010);
        send_item(OP_MEASURE, 12'd0);
        advance_to_dry();
        send_item(OP_CAL, 12'd2000);
        send_item(OP_CAL, 12'd2000);
        send_item(OP_MEASURE, 12'd2010);
    endtask

    // Measurements, about half aimed between the references and the rest full-range, with whole
    // calibration sequences and stray calibration steps mixed in.
    task automatic test_random_traffic(input int count, input bit allow_idle);
        int          stop_at;
        int          next_toggle;
        int          next_drain;
        int          pick;
        int          lo;
        int          hi;
        int          swap;
        logic [11:0] dry_sample;
        logic [11:0] wet_sample;
        stop_at     = items_sent + count;
        next_toggle = items_sent;
        next_drain  = items_sent + 300;
        idle_on     = allow_idle;
        while (items_sent < stop_at) begin
            // Idling comes and goes in stretches of about a hundred items.
            if (allow_idle && items_sent >= next_toggle) begin
                idle_on     = ($urandom_range(0, 3) != 0);
                next_toggle = items_sent + 100;
            end
            if (allow_idle && items_sent >= next_drain) begin
                hold_until_drained();
                next_drain = items_sent + 300;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                advance_to_dry();
                dry_sample = 12'($urandom_range(1000, 4095));
                if ($urandom_range(0, 4) != 0) begin
                    wet_sample = 12'($urandom_range(0, dry_sample));
                end else begin
                    wet_sample = 12'($urandom_range(0, 4095));
                end
                send_item(OP_CAL, dry_sample);
                send_item(OP_CAL, wet_sample);
            end else if (pick < 12) begin
                send_item(OP_CAL, 12'($urandom_range(0, 4095)));
            end else if (pick < 60) begin
                // Aim at the band between the references, a little past each end.
                lo = (int'(wet_mv_s) * 4096) / FULL_SCALE_MV - 20;
                hi = (int'(dry_mv_s) * 4096) / FULL_SCALE_MV + 20;
                if (lo > hi) begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
                if (lo < 0) begin
                    lo = 0;
                end
                if (hi > 4095) begin
                    hi = 4095;
                end
                send_item(OP_MEASURE, 12'($urandom_range(lo, hi)));
            end else begin
                send_item(OP_MEASURE, 12'($urandom_range(0, 4095)));
            end
        end
    endtask

    // Result side: stalls in bursts while idling is on.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Compares every accepted result with the oldest predicted reading.
    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            results_checked++;
            if (pending_readings.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("result with no item outstanding: %p", out_item);
                end
            end else begin
                want = pending_readings.pop_front();
                if (want.millivolts !== out_item.millivolts
                    || want.moisture_percent !== out_item.moisture_percent
                    || want.is_calibrated !== out_item.is_calibrated
                    || want.cal_phase !== out_item.cal_phase) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("reading %0d: mv %0d/%0d pct %0d/%0d cal %0b/%0b phase %0d/%0d",
                                 results_checked,
                                 want.millivolts, out_item.millivolts,
                                 want.moisture_percent, out_item.moisture_percent,
                                 want.is_calibrated, out_item.is_calibrated,
                                 want.cal_phase, out_item.cal_phase);
                    end
                end
            end
        end
    end

    // Ends the run if neither side moves an item for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("moisture_two_point_calibration verification failed");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_uncalibrated_readings();
        test_calibration_cycle();
        test_inverted_references();
        test_random_traffic(1450, 1'b1);
        test_random_traffic(250, 1'b0);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d items: %0d calibration steps and %0d measurements.",
                 items_sent, cal_steps, measurements);
        $display("Checked %0d readings, %0d of them between wet and dry; %0d failures.",
                 results_checked, partial_reads, fail_count);
        if (fail_count == 0 && pending_readings.size() == 0) begin
            $display("moisture_two_point_calibration verification clean");
        end else begin
            $display("moisture_two_point_calibration verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/mtpc_pkg.sv
rtl/mtpc_div.sv
rtl/moisture_two_point_calibration.sv
dv/tb_moisture_two_point_calibration.sv
